// ===== sv/nv12_letterbox_nearest_to_rgb_top_defines.svh =====
// assertion macros for the nv12 letterbox resize block
`ifndef NV12_LETTERBOX_NEAREST_TO_RGB_TOP_DEFINES_SVH
`define NV12_LETTERBOX_NEAREST_TO_RGB_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst is high
`define NV12LB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst is high
`define NV12LB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nv12lb_pkg.sv =====
// shared types and constants for the nv12 letterbox resize block
`default_nettype none

package nv12lb_pkg;

  // request codes
  localparam logic [1:0] REQ_LUMA   = 2'd0;
  localparam logic [1:0] REQ_CHROMA = 2'd1;
  localparam logic [1:0] REQ_EMIT   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_INVERSE_SCALE = 3'd2;
  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd4;
  localparam logic [2:0] REG_PAD_LEFT_COLS = 3'd5;
  localparam logic [2:0] REG_PAD_TOP_ROWS  = 3'd6;

  // padding grey level
  localparam logic [7:0] GREY = 8'd114;

  // color conversion coefficients
  localparam logic signed [10:0] COEF_Y   = 11'sd298;
  localparam logic signed [10:0] COEF_RV  = 11'sd409;
  localparam logic signed [10:0] COEF_GU  = 11'sd100;
  localparam logic signed [10:0] COEF_GV  = 11'sd208;
  localparam logic signed [10:0] COEF_BU  = 11'sd516;
  localparam logic signed [9:0]  LUMA_OFS = 10'sd16;
  localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;
  localparam logic signed [19:0] ROUND_OFS  = 20'sd128;

  // emit sequencer
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ADDR = 7'b0000100,
    ST_RD0  = 7'b0001000,
    ST_RD1  = 7'b0010000,
    ST_CONV = 7'b0100000,
    ST_SUM  = 7'b1000000
  } emit_state_t;

endpackage

`default_nettype wire

// ===== sv/nv12_letterbox_nearest_to_rgb_top.sv =====
// top level: nv12 frame store with nearest-neighbor letterbox resize to rgb
`default_nettype none
`include "nv12_letterbox_nearest_to_rgb_top_defines.svh"
// loads (luma or chroma byte) are written on the accepting edge, a new beat every cycle while not busy
// padding pixels: result strobe in the cycle after the accepting edge, one per cycle while not busy
// window pixels: busy from ST_MUL through ST_SUM, done after ST_SUM, one pixel at a time;
//   the states are set by the two scale multiplies, the address multiply and two chroma reads on one ram port
// results are strobed with done for one cycle; the receiver cannot stall
// synchronous reset clears pointers, output position and sequencer, loads config defaults; rams are not cleared

module nv12_letterbox_nearest_to_rgb_top #(
  parameter int FRAME_WIDTH       = 640,
  parameter int FRAME_HEIGHT      = 640,
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  data_byte,
  // result channel
  output logic             done,
  output logic      [7:0]  red,
  output logic      [7:0]  green,
  output logic      [7:0]  blue,
  output logic             is_padding,
  output logic             last_of_frame,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  import nv12lb_pkg::*;

  localparam int LUMA_DEPTH   = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int CHROMA_DEPTH = LUMA_DEPTH / 2;
  localparam int LA_W  = $clog2(LUMA_DEPTH);
  localparam int CA_W  = $clog2(CHROMA_DEPTH);
  localparam int CI_W  = CA_W + 2;
  localparam int COL_W = $clog2(FRAME_WIDTH);
  localparam int ROW_W = $clog2(FRAME_HEIGHT);
  localparam int SW_W  = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SH_W  = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int SX_W  = $clog2(MAX_SOURCE_WIDTH);
  localparam int SY_W  = $clog2(MAX_SOURCE_HEIGHT);

  // configuration registers
  logic [8:0]  source_width;
  logic [8:0]  source_height;
  logic [23:0] inverse_scale;
  logic [9:0]  window_width;
  logic [9:0]  window_height;
  logic [9:0]  pad_left_cols;
  logic [9:0]  pad_top_rows;

  // control state
  emit_state_t      state;
  emit_state_t      state_next;
  logic [LA_W-1:0]  luma_ptr;
  logic [CA_W-1:0]  chroma_ptr;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  // emit datapath registers
  logic [9:0]      dx;
  logic [9:0]      dy;
  logic            last_q;
  logic [SX_W-1:0] sx;
  logic [SY_W-1:0] sy;
  logic [LA_W-1:0] luma_addr;
  logic [CI_W-1:0] ci;
  logic [CA_W-1:0] ci1;
  logic [7:0]      u_q;

  // combinational
  logic            accept;
  logic            luma_we;
  logic            chroma_we;
  logic            emit;
  logic            col_end;
  logic            row_end;
  logic            last_frame;
  logic [10:0]     x_ext;
  logic [10:0]     y_ext;
  logic [10:0]     dx_full;
  logic [10:0]     dy_full;
  logic            in_window;
  logic [SW_W-1:0] w_lim;
  logic [SH_W-1:0] h_lim;
  logic [SW_W-1:0] w_m1;
  logic [SH_W-1:0] h_m1;
  logic [33:0]     prod_x;
  logic [33:0]     prod_y;
  logic [17:0]     px;
  logic [17:0]     py;
  logic [SX_W-1:0] sx_next;
  logic [SY_W-1:0] sy_next;
  logic [LA_W:0]   la_full;
  logic [CI_W-1:0] ci_full;
  logic [CI_W-1:0] ci_inc;
  logic [CA_W-1:0] ci0;
  logic [CA_W-1:0] ci1_next;
  logic [CA_W-1:0] chroma_raddr;
  logic [7:0]      luma_rdata;
  logic [7:0]      chroma_rdata;
  logic            csc_valid;
  logic [7:0]      csc_red;
  logic [7:0]      csc_green;
  logic [7:0]      csc_blue;

  // command beat handshake
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign luma_we   = accept && (req_type == REQ_LUMA);
  assign chroma_we = accept && (req_type == REQ_CHROMA);
  assign emit      = accept && (req_type == REQ_EMIT);

  // output raster position
  assign col_end    = (out_col == COL_W'(FRAME_WIDTH - 1));
  assign row_end    = (out_row == ROW_W'(FRAME_HEIGHT - 1));
  assign last_frame = col_end && row_end;

  // letterbox window test, offsets into the scaled image
  assign x_ext   = 11'(out_col);
  assign y_ext   = 11'(out_row);
  assign dx_full = x_ext - 11'(pad_left_cols);
  assign dy_full = y_ext - 11'(pad_top_rows);
  assign in_window = (x_ext >= 11'(pad_left_cols)) && (dx_full < 11'(window_width)) &&
                     (y_ext >= 11'(pad_top_rows)) && (dy_full < 11'(window_height));

  // source size limited to 1..max
  always_comb begin
    if (source_width == 9'd0) begin
      w_lim = SW_W'(1);
    end else if (32'(source_width) > MAX_SOURCE_WIDTH) begin
      w_lim = SW_W'(MAX_SOURCE_WIDTH);
    end else begin
      w_lim = SW_W'(source_width);
    end
    if (source_height == 9'd0) begin
      h_lim = SH_W'(1);
    end else if (32'(source_height) > MAX_SOURCE_HEIGHT) begin
      h_lim = SH_W'(MAX_SOURCE_HEIGHT);
    end else begin
      h_lim = SH_W'(source_height);
    end
  end

  assign w_m1 = w_lim - SW_W'(1);
  assign h_m1 = h_lim - SH_W'(1);

  // nearest source pixel: offset times q8.16 inverse scale, truncated and clamped
  assign prod_x = 34'(dx) * 34'(inverse_scale);
  assign prod_y = 34'(dy) * 34'(inverse_scale);
  assign px     = prod_x[33:16];
  assign py     = prod_y[33:16];

  always_comb begin
    if (px > 18'(w_m1)) begin
      sx_next = SX_W'(w_m1);
    end else begin
      sx_next = SX_W'(px);
    end
    if (py > 18'(h_m1)) begin
      sy_next = SY_W'(h_m1);
    end else begin
      sy_next = SY_W'(py);
    end
  end

  // store addresses: luma in range by construction, chroma wraps at most once
  assign la_full = (LA_W + 1)'(sy) * (LA_W + 1)'(w_lim) + (LA_W + 1)'(sx);
  assign ci_full = CI_W'(sy[SY_W-1:1]) * CI_W'(w_lim) + CI_W'({sx[SX_W-1:1], 1'b0});
  assign ci_inc  = ci + CI_W'(1);

  always_comb begin
    if (ci >= CI_W'(CHROMA_DEPTH)) begin
      ci0 = CA_W'(ci - CI_W'(CHROMA_DEPTH));
    end else begin
      ci0 = CA_W'(ci);
    end
    if (ci_inc >= CI_W'(CHROMA_DEPTH)) begin
      ci1_next = CA_W'(ci_inc - CI_W'(CHROMA_DEPTH));
    end else begin
      ci1_next = CA_W'(ci_inc);
    end
  end

  // u is read in the first read cycle, v in the second
  assign chroma_raddr = (state == ST_RD1) ? ci1 : ci0;

  // sequencer for a window pixel
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (emit && in_window) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_RD0;
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_CONV;
      ST_CONV: state_next = ST_SUM;
      ST_SUM:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      luma_ptr      <= '0;
      chroma_ptr    <= '0;
      out_col       <= '0;
      out_row       <= '0;
      done          <= 1'b0;
      source_width  <= 9'd256;
      source_height <= 9'd256;
      inverse_scale <= 24'd65536;
      window_width  <= 10'd256;
      window_height <= 10'd256;
      pad_left_cols <= 10'd192;
      pad_top_rows  <= 10'd192;
    end else begin
      state <= state_next;
      done  <= (emit && !in_window) || (state == ST_SUM);

      if (luma_we) begin
        luma_ptr <= (luma_ptr == LA_W'(LUMA_DEPTH - 1)) ? '0 : luma_ptr + LA_W'(1);
      end
      if (chroma_we) begin
        chroma_ptr <= (chroma_ptr == CA_W'(CHROMA_DEPTH - 1)) ? '0 : chroma_ptr + CA_W'(1);
      end

      // raster advance on every emit beat, wrapping at the frame end
      if (emit) begin
        if (col_end) begin
          out_col <= '0;
          out_row <= row_end ? '0 : out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  source_width  <= cfg_data[8:0];
          REG_SOURCE_HEIGHT: source_height <= cfg_data[8:0];
          REG_INVERSE_SCALE: inverse_scale <= cfg_data;
          REG_WINDOW_WIDTH:  window_width  <= cfg_data[9:0];
          REG_WINDOW_HEIGHT: window_height <= cfg_data[9:0];
          REG_PAD_LEFT_COLS: pad_left_cols <= cfg_data[9:0];
          REG_PAD_TOP_ROWS:  pad_top_rows  <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (emit) begin
      dx     <= dx_full[9:0];
      dy     <= dy_full[9:0];
      last_q <= last_frame;
    end
    if (state == ST_MUL) begin
      sx <= sx_next;
      sy <= sy_next;
    end
    if (state == ST_ADDR) begin
      luma_addr <= LA_W'(la_full);
      ci        <= ci_full;
    end
    if (state == ST_RD0) begin
      ci1 <= ci1_next;
    end
    if (state == ST_RD1) begin
      u_q <= chroma_rdata;
    end

    // result beat: grey right after a padding emit, converted color after the sum cycle
    if (emit && !in_window) begin
      red           <= GREY;
      green         <= GREY;
      blue          <= GREY;
      is_padding    <= 1'b1;
      last_of_frame <= last_frame;
    end else if (state == ST_SUM) begin
      red           <= csc_red;
      green         <= csc_green;
      blue          <= csc_blue;
      is_padding    <= 1'b0;
      last_of_frame <= last_q;
    end
  end

  // frame stores
  nv12lb_ram #(
    .WIDTH (8),
    .DEPTH (LUMA_DEPTH)
  ) u_luma_ram (
    .clk   (clk),
    .we    (luma_we),
    .waddr (luma_ptr),
    .wdata (data_byte),
    .raddr (luma_addr),
    .rdata (luma_rdata)
  );

  nv12lb_ram #(
    .WIDTH (8),
    .DEPTH (CHROMA_DEPTH)
  ) u_chroma_ram (
    .clk   (clk),
    .we    (chroma_we),
    .waddr (chroma_ptr),
    .wdata (data_byte),
    .raddr (chroma_raddr),
    .rdata (chroma_rdata)
  );

  // color conversion; luma read data holds since its address only moves in ST_ADDR
  nv12lb_csc u_csc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (state == ST_CONV),
    .luma      (luma_rdata),
    .cb        (u_q),
    .cr        (chroma_rdata),
    .out_valid (csc_valid),
    .red       (csc_red),
    .green     (csc_green),
    .blue      (csc_blue)
  );

  // checks
  `NV12LB_ASSERT_SAME(a_done_only_idle, done, !busy, "result beat while sequencer busy")
  `NV12LB_ASSERT_SAME(a_csc_in_sum, state == ST_SUM, csc_valid, "converter not ready in sum cycle")
  `NV12LB_ASSERT_NEXT(a_window_goes_busy, emit && in_window, busy && !done, "window emit did not start sequencer")
  `NV12LB_ASSERT_NEXT(a_pad_next_cycle, emit && !in_window, done && is_padding, "padding beat not delivered next cycle")

endmodule

`default_nettype wire

// ===== sv/nv12lb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module nv12lb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/nv12lb_csc.sv =====
// yuv to rgb conversion: registered products, then sum, floor and clamp
`default_nettype none

module nv12lb_csc (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] luma,
  input  wire logic [7:0] cb,
  input  wire logic [7:0] cr,
  output logic            out_valid,
  output logic      [7:0] red,
  output logic      [7:0] green,
  output logic      [7:0] blue
);

  import nv12lb_pkg::*;

  logic signed [9:0]  c_val;
  logic signed [9:0]  d_val;
  logic signed [9:0]  e_val;
  logic signed [19:0] y_term;
  logic signed [19:0] rv_term;
  logic signed [19:0] gu_term;
  logic signed [19:0] gv_term;
  logic signed [19:0] bu_term;
  logic signed [19:0] r_sum;
  logic signed [19:0] g_sum;
  logic signed [19:0] b_sum;

  function automatic logic [7:0] to_byte(input logic signed [19:0] sum);
    logic signed [19:0] q;
    q = sum >>> 8;
    if (q < 20'sd0) begin
      return 8'd0;
    end else if (q > 20'sd255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

  assign c_val = $signed({2'b00, luma}) - LUMA_OFS;
  assign d_val = $signed({2'b00, cb}) - CHROMA_OFS;
  assign e_val = $signed({2'b00, cr}) - CHROMA_OFS;

  always_ff @(posedge clk) begin
    y_term  <= 20'(c_val) * 20'(COEF_Y);
    rv_term <= 20'(e_val) * 20'(COEF_RV);
    gu_term <= 20'(d_val) * 20'(COEF_GU);
    gv_term <= 20'(e_val) * 20'(COEF_GV);
    bu_term <= 20'(d_val) * 20'(COEF_BU);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  assign r_sum = y_term + rv_term + ROUND_OFS;
  assign g_sum = y_term - gu_term - gv_term + ROUND_OFS;
  assign b_sum = y_term + bu_term + ROUND_OFS;

  assign red   = to_byte(r_sum);
  assign green = to_byte(g_sum);
  assign blue  = to_byte(b_sum);

endmodule

`default_nettype wire
